FILE: rtl/core/ucog_pkg.sv
// ucog_pkg: shared types and constants for the usb connector overtemp guard
// no dependencies; compiled first
`timescale 1ns / 1ps

package ucog_pkg;

	localparam int TempW   = 8;
	localparam int DelayW  = 14;
	localparam int CountW  = 12;
	localparam int CfgIdxW = 3;
	localparam int CfgDatW = 8;

	localparam logic signed [CountW-1:0] CntInsert = 12'sd1100;
	localparam logic signed [CountW-1:0] CntEnd    = 12'sd1001;
	localparam logic signed [CountW-1:0] CntIdle   = -12'sd1;

	localparam logic [DelayW-1:0] FastMs   = 14'd300;
	localparam logic [DelayW-1:0] NormalMs = 14'd1000;
	localparam logic [DelayW-1:0] FirstMs  = 14'd10000;

	typedef enum logic {
		OP_CHARGER = 1'b0,
		OP_TICK    = 1'b1
	} op_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_GUARD_ENABLE      = 3'd0,
		REG_USB_PROTECT_LEVEL = 3'd1,
		REG_USB_RECOVER_LEVEL = 3'd2,
		REG_DELTA_OPEN_LEVEL  = 3'd3,
		REG_DELTA_CLOSE_LEVEL = 3'd4,
		REG_DELTA_FAST_LEVEL  = 3'd5
	} reg_idx_t;

	localparam logic signed [TempW-1:0] RstUsbProtect  = 8'sd57;
	localparam logic signed [TempW-1:0] RstUsbRecover  = 8'sd54;
	localparam logic signed [TempW-1:0] RstDeltaOpen   = 8'sd15;
	localparam logic signed [TempW-1:0] RstDeltaClose  = 8'sd8;
	localparam logic signed [TempW-1:0] RstDeltaFast   = 8'sd10;

	typedef struct packed {
		logic                    op;
		logic                    charging;
		logic signed [TempW-1:0] conn_temp;
		logic signed [TempW-1:0] batt_temp;
		logic                    batt_valid;
	} item_t;

	typedef struct packed {
		logic              timer_started;
		logic [DelayW-1:0] delay_ms;
		logic              mosfet_open;
		logic              fast_poll;
		logic              protect_mode;
		logic              wake_held;
	} result_t;

endpackage

FILE: rtl/core/ucog_if.sv
// ucog_if: valid/ready channel interfaces for items, results and config writes
// depends on ucog_pkg for field widths
`timescale 1ns / 1ps

interface ucog_item_if import ucog_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    op;
	logic                    charging;
	logic signed [TempW-1:0] conn_temp;
	logic signed [TempW-1:0] batt_temp;
	logic                    batt_valid;

	modport source (output valid, op, charging, conn_temp, batt_temp, batt_valid,
		input ready);
	modport sink (input valid, op, charging, conn_temp, batt_temp, batt_valid,
		output ready);
endinterface

interface ucog_result_if import ucog_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              timer_started;
	logic [DelayW-1:0] delay_ms;
	logic              mosfet_open;
	logic              fast_poll;
	logic              protect_mode;
	logic              wake_held;

	modport source (output valid, timer_started, delay_ms, mosfet_open, fast_poll,
		protect_mode, wake_held, input ready);
	modport sink (input valid, timer_started, delay_ms, mosfet_open, fast_poll,
		protect_mode, wake_held, output ready);
endinterface

interface ucog_cfg_if import ucog_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CfgIdxW-1:0] index;
	logic [CfgDatW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/usb_connector_overtemp_guard.sv
// usb_connector_overtemp_guard: top level of the connector overtemp guard
// depends on ucog_pkg and the channel interfaces in ucog_if
`timescale 1ns / 1ps

// usage
//   item:   one word per charger event (op 0) or check tick (op 1), with
//           charger presence, connector and battery temperatures
//   result: one word per item: whether a next check is scheduled and its
//           delay, plus mosfet, poll rate, protect mode and wake hold
//   cfg:    register writes (index 0..5), always ready; write only while idle
// timing
//   an accepted item is registered in the input register, and its result then in the result register;
//   one item per cycle is taken while results are taken, limited only by the input and result registers
// reset
//   arst_n clears both stages, loads the check counter with 1100, closes the
//   mosfet and restores the register defaults; the first start waits 10 s
// stall
//   a held result keeps the item register free for one more word; with both
//   full, item ready drops until the result is taken
module usb_connector_overtemp_guard import ucog_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	ucog_item_if.sink    item,
	ucog_result_if.source result,
	ucog_cfg_if.sink     cfg
);

	logic                    guard_enable_q;
	logic signed [TempW-1:0] usb_protect_q;
	logic signed [TempW-1:0] usb_recover_q;
	logic signed [TempW-1:0] delta_open_q;
	logic signed [TempW-1:0] delta_close_q;
	logic signed [TempW-1:0] delta_fast_q;

	logic signed [CountW-1:0] count_q;
	logic                     mosfet_q;
	logic                     fast_q;
	logic                     protect_q;
	logic                     wake_q;
	logic                     armed_q;
	logic                     first_q;

	item_t   item_s1;
	logic    valid_s1;
	result_t res_q;
	logic    res_valid_q;

	logic advance;
	logic item_acc;

	logic signed [CountW-1:0] count_d;
	logic                     mosfet_d;
	logic                     fast_d;
	logic                     protect_d;
	logic                     wake_d;
	logic                     armed_d;
	logic                     first_d;
	logic                     started_d;
	logic [DelayW-1:0]        delay_d;
	logic signed [TempW:0]    delta;

	assign advance    = !res_valid_q || result.ready;
	assign item.ready = !valid_s1 || advance;
	assign item_acc   = item.valid && item.ready;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guard_enable_q <= 1'b1;
			usb_protect_q  <= RstUsbProtect;
			usb_recover_q  <= RstUsbRecover;
			delta_open_q   <= RstDeltaOpen;
			delta_close_q  <= RstDeltaClose;
			delta_fast_q   <= RstDeltaFast;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_GUARD_ENABLE:      guard_enable_q <= cfg.data[0];
				REG_USB_PROTECT_LEVEL: usb_protect_q  <= cfg.data;
				REG_USB_RECOVER_LEVEL: usb_recover_q  <= cfg.data;
				REG_DELTA_OPEN_LEVEL:  delta_open_q   <= cfg.data;
				REG_DELTA_CLOSE_LEVEL: delta_close_q  <= cfg.data;
				REG_DELTA_FAST_LEVEL:  delta_fast_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			item_s1.op         <= item.op;
			item_s1.charging   <= item.charging;
			item_s1.conn_temp  <= item.conn_temp;
			item_s1.batt_temp  <= item.batt_temp;
			item_s1.batt_valid <= item.batt_valid;
		end
	end

	always_comb begin
		count_d   = count_q;
		mosfet_d  = mosfet_q;
		fast_d    = fast_q;
		protect_d = protect_q;
		wake_d    = wake_q;
		armed_d   = armed_q;
		first_d   = first_q;
		started_d = 1'b0;
		delay_d   = '0;
		delta     = item_s1.batt_valid ?
			({item_s1.conn_temp[TempW-1], item_s1.conn_temp} -
			 {item_s1.batt_temp[TempW-1], item_s1.batt_temp}) : '0;
		if (item_s1.op == OP_CHARGER) begin
			if (guard_enable_q && item_s1.charging && !armed_q) begin
				count_d   = CntInsert;
				delay_d   = first_q ? FirstMs : '0;
				first_d   = 1'b0;
				armed_d   = 1'b1;
				started_d = 1'b1;
			end
		end else begin
			armed_d = 1'b0;
			if (count_q == CntIdle && !item_s1.charging) begin
				mosfet_d  = 1'b0;
				fast_d    = 1'b0;
				protect_d = 1'b0;
				wake_d    = 1'b0;
			end else begin
				// poll rate and protect mode
				priority if (delta > $signed({delta_fast_q[TempW-1], delta_fast_q})) begin
					fast_d    = 1'b1;
					count_d   = '0;
					protect_d = 1'b1;
				end else if (count_q > CntEnd) begin
					count_d   = count_q - 12'sd1;
					fast_d    = 1'b1;
					protect_d = 1'b0;
				end else if (count_q == CntEnd) begin
					count_d   = CntIdle;
					fast_d    = 1'b0;
					protect_d = 1'b0;
					wake_d    = 1'b0;
				end else if (!count_q[CountW-1]) begin
					count_d   = count_q + 12'sd1;
					fast_d    = 1'b1;
					protect_d = 1'b1;
				end else begin
					fast_d    = 1'b0;
					protect_d = 1'b0;
				end
				// mosfet hysteresis
				if (delta >= $signed({delta_open_q[TempW-1], delta_open_q}) &&
					item_s1.conn_temp >= usb_protect_q) begin
					wake_d   = 1'b1;
					mosfet_d = 1'b1;
				end else if (delta <= $signed({delta_close_q[TempW-1], delta_close_q}) &&
					item_s1.conn_temp <= usb_recover_q) begin
					mosfet_d = 1'b0;
				end
				delay_d   = fast_d ? FastMs : NormalMs;
				armed_d   = 1'b1;
				started_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= CntInsert;
			mosfet_q    <= 1'b0;
			fast_q      <= 1'b0;
			protect_q   <= 1'b0;
			wake_q      <= 1'b0;
			armed_q     <= 1'b0;
			first_q     <= 1'b1;
			res_valid_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			count_q     <= count_d;
			mosfet_q    <= mosfet_d;
			fast_q      <= fast_d;
			protect_q   <= protect_d;
			wake_q      <= wake_d;
			armed_q     <= armed_d;
			first_q     <= first_d;
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_q.timer_started <= started_d;
			res_q.delay_ms      <= delay_d;
			res_q.mosfet_open   <= mosfet_d;
			res_q.fast_poll     <= fast_d;
			res_q.protect_mode  <= protect_d;
			res_q.wake_held     <= wake_d;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.timer_started = res_q.timer_started;
	assign result.delay_ms      = res_q.delay_ms;
	assign result.mosfet_open   = res_q.mosfet_open;
	assign result.fast_poll     = res_q.fast_poll;
	assign result.protect_mode  = res_q.protect_mode;
	assign result.wake_held     = res_q.wake_held;

endmodule

FILE: rtl/core/ucog_checker.sv
// ucog_checker: port-level assertions for the usb connector overtemp guard
// depends on ucog_pkg; bound to usb_connector_overtemp_guard below
`timescale 1ns / 1ps

module ucog_checker import ucog_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_ready,
	input logic              timer_started,
	input logic [DelayW-1:0] delay_ms,
	input logic              fast_poll,
	input logic              protect_mode
);

	// held result stays put
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(delay_ms) && $stable(timer_started))
		else $error("result changed while stalled");

	// no schedule means no delay
	a_no_sched_delay: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !timer_started |-> delay_ms == '0)
		else $error("delay without schedule");

	// tick delays follow the poll rate
	a_tick_delay: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && timer_started && delay_ms != FirstMs && delay_ms != '0 |->
			(fast_poll && delay_ms == FastMs) || (!fast_poll && delay_ms == NormalMs))
		else $error("tick delay does not match poll rate");

	// protect mode only runs at the fast rate
	a_protect_fast: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && protect_mode |-> fast_poll)
		else $error("protect mode at normal rate");

endmodule

bind usb_connector_overtemp_guard ucog_checker u_ucog_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.result_valid  (result.valid),
	.result_ready  (result.ready),
	.timer_started (result.timer_started),
	.delay_ms      (result.delay_ms),
	.fast_poll     (result.fast_poll),
	.protect_mode  (result.protect_mode)
);

FILE: dv/usb_connector_overtemp_guard_tb.sv
// usb_connector_overtemp_guard_tb: self-checking bench for the connector overtemp guard
// drives charger events and check ticks, predicts each result word in-bench and compares
// depends on ucog_pkg, the ucog_if channel interfaces and the guard top level
`timescale 1ns / 1ps

module usb_connector_overtemp_guard_tb;
	import ucog_pkg::*;

	localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
	localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

	logic clk = 1'b0;
	logic arst_n;

	ucog_item_if   item_bus();
	ucog_result_if result_bus();
	ucog_cfg_if    cfg_bus();

	usb_connector_overtemp_guard uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	// guard registers as the bench believes them
	logic lim_enable      = 1'b1;
	int   lim_usb_protect = 57;
	int   lim_usb_recover = 54;
	int   lim_delta_open  = 15;
	int   lim_delta_close = 8;
	int   lim_delta_fast  = 10;

	// guard state as the bench believes it
	int   poll_count    = 1100;
	logic fet_open      = 1'b0;
	logic poll_fast     = 1'b0;
	logic protect_on    = 1'b0;
	logic wake_on       = 1'b0;
	logic check_armed   = 1'b0;
	logic first_pending = 1'b1;

	result_t expected_results[$];
	int      mismatches = 0;
	int      results_seen = 0;
	int      src_gap_pct = 0;
	int      sink_stall_pct = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int rnd(int lo, int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	function automatic result_t guard_predict(item_t w);
		result_t r;
		int      tusb;
		int      delta;
		r = '0;
		if (w.op == OP_CHARGER) begin
			if (lim_enable && w.charging && !check_armed) begin
				poll_count = int'(CntInsert);
				r.delay_ms = first_pending ? FirstMs : '0;
				first_pending = 1'b0;
				check_armed = 1'b1;
				r.timer_started = 1'b1;
			end
		end else begin
			check_armed = 1'b0;
			if (poll_count == int'(CntIdle) && !w.charging) begin
				fet_open = 1'b0;
				poll_fast = 1'b0;
				protect_on = 1'b0;
				wake_on = 1'b0;
			end else begin
				tusb = int'($signed(w.conn_temp));
				delta = w.batt_valid ? tusb - int'($signed(w.batt_temp)) : 0;
				if (delta > lim_delta_fast) begin
					poll_fast = 1'b1;
					poll_count = 0;
					protect_on = 1'b1;
				end else if (poll_count > int'(CntEnd)) begin
					poll_count--;
					poll_fast = 1'b1;
					protect_on = 1'b0;
				end else if (poll_count == int'(CntEnd)) begin
					poll_count = int'(CntIdle);
					poll_fast = 1'b0;
					protect_on = 1'b0;
					wake_on = 1'b0;
				end else if (poll_count >= 0) begin
					poll_count++;
					poll_fast = 1'b1;
					protect_on = 1'b1;
				end else begin
					poll_fast = 1'b0;
					protect_on = 1'b0;
				end
				if (delta >= lim_delta_open && tusb >= lim_usb_protect) begin
					wake_on = 1'b1;
					fet_open = 1'b1;
				end else if (delta <= lim_delta_close && tusb <= lim_usb_recover) begin
					fet_open = 1'b0;
				end
				r.delay_ms = poll_fast ? FastMs : NormalMs;
				check_armed = 1'b1;
				r.timer_started = 1'b1;
			end
		end
		r.mosfet_open = fet_open;
		r.fast_poll = poll_fast;
		r.protect_mode = protect_on;
		r.wake_held = wake_on;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("ERROR: result word %0d: %s", results_seen, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("word with no item pending");
			end else begin
				want = expected_results.pop_front();
				if (result_bus.timer_started !== want.timer_started)
					report_mismatch($sformatf("timer_started got %0b expected %0b",
						result_bus.timer_started, want.timer_started));
				if (result_bus.delay_ms !== want.delay_ms)
					report_mismatch($sformatf("delay_ms got %0d expected %0d",
						result_bus.delay_ms, want.delay_ms));
				if (result_bus.mosfet_open !== want.mosfet_open)
					report_mismatch($sformatf("mosfet_open got %0b expected %0b",
						result_bus.mosfet_open, want.mosfet_open));
				if (result_bus.fast_poll !== want.fast_poll)
					report_mismatch($sformatf("fast_poll got %0b expected %0b",
						result_bus.fast_poll, want.fast_poll));
				if (result_bus.protect_mode !== want.protect_mode)
					report_mismatch($sformatf("protect_mode got %0b expected %0b",
						result_bus.protect_mode, want.protect_mode));
				if (result_bus.wake_held !== want.wake_held)
					report_mismatch($sformatf("wake_held got %0b expected %0b",
						result_bus.wake_held, want.wake_held));
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else begin
			result_bus.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	task automatic send_word(item_t w);
		while ($urandom_range(0, 99) < src_gap_pct) begin
			item_bus.valid <= 1'b0;
			@(posedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.op <= w.op;
		item_bus.charging <= w.charging;
		item_bus.conn_temp <= w.conn_temp;
		item_bus.batt_temp <= w.batt_temp;
		item_bus.batt_valid <= w.batt_valid;
		@(posedge clk);
		while (!item_bus.ready) @(posedge clk);
		expected_results.push_back(guard_predict(w));
	endtask

	task automatic drain_results();
		item_bus.valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= val;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		case (idx)
			REG_GUARD_ENABLE:      lim_enable = val[0];
			REG_USB_PROTECT_LEVEL: lim_usb_protect = int'($signed(val));
			REG_USB_RECOVER_LEVEL: lim_usb_recover = int'($signed(val));
			REG_DELTA_OPEN_LEVEL:  lim_delta_open = int'($signed(val));
			REG_DELTA_CLOSE_LEVEL: lim_delta_close = int'($signed(val));
			REG_DELTA_FAST_LEVEL:  lim_delta_fast = int'($signed(val));
			default: ;
		endcase
	endtask

	task automatic program_regs(logic en, int prot, int rec, int opn, int cls, int fst);
		drain_results();
		write_reg(REG_GUARD_ENABLE, {7'b0, en} | (8'($urandom) & 8'hfe));
		write_reg(REG_USB_PROTECT_LEVEL, 8'(prot));
		write_reg(REG_USB_RECOVER_LEVEL, 8'(rec));
		write_reg(REG_DELTA_OPEN_LEVEL, 8'(opn));
		write_reg(REG_DELTA_CLOSE_LEVEL, 8'(cls));
		write_reg(REG_DELTA_FAST_LEVEL, 8'(fst));
		write_reg(RegSpareLo, 8'($urandom));
		write_reg(RegSpareHi, 8'($urandom));
		cfg_bus.valid <= 1'b0;
	endtask

	function automatic item_t make_word(op_t op, logic chg, int usb, int batt, logic bv);
		item_t w;
		w.op = op;
		w.charging = chg;
		w.conn_temp = 8'(usb);
		w.batt_temp = 8'(batt);
		w.batt_valid = bv;
		return w;
	endfunction

	// tick whose temperatures give the wanted delta, often near the protect level
	function automatic item_t tick_word(logic chg, int delta);
		int lo;
		int hi;
		int b;
		lo = (delta > 0) ? -128 : -128 - delta;
		hi = (delta > 0) ? 127 - delta : 127;
		b = lim_usb_protect + rnd(-8, 8) - delta;
		if ($urandom_range(0, 1) || b < lo || b > hi) b = rnd(lo, hi);
		return make_word(OP_TICK, chg, b + delta, b, 1'b1);
	endfunction

	function automatic item_t charger_noise();
		item_t w;
		w = item_t'($urandom);
		w.op = OP_CHARGER;
		return w;
	endfunction

	function automatic int rnd_level();
		int sel;
		sel = rnd(0, 9);
		if (sel < 2) return -128;
		if (sel < 4) return 127;
		return rnd(-128, 127);
	endfunction

	// start, tick with deltas at or below the fast level until the counter idles, then stop
	task automatic run_cool_session(int idle_ticks);
		int   n;
		int   sel;
		item_t w;
		n = 0;
		send_word(make_word(OP_CHARGER, 1'b1, rnd(-128, 127), rnd(-128, 127), 1'($urandom)));
		while (poll_count != int'(CntIdle) && n < 300) begin
			sel = rnd(0, 99);
			if (sel < 10) begin
				w = charger_noise();
			end else if (sel < 20) begin
				w = tick_word(1'b0, rnd(lim_delta_fast - 80, lim_delta_fast));
			end else if (sel < 30) begin
				w = make_word(OP_TICK, 1'($urandom), rnd(-128, 127), rnd(-128, 127), 1'b0);
			end else begin
				w = tick_word(1'b1, rnd(lim_delta_fast - 80, lim_delta_fast));
			end
			send_word(w);
			if (n == 50) drain_results();
			n++;
		end
		repeat (idle_ticks) send_word(tick_word(1'b1, rnd(lim_delta_fast - 80, lim_delta_fast)));
		send_word(tick_word(1'b0, rnd(-40, 0)));
	endtask

	task automatic test_first_start();
		send_word(make_word(OP_CHARGER, 1'b0, 20, 20, 1'b1));
		send_word(make_word(OP_CHARGER, 1'b1, -128, 127, 1'b0));
		send_word(make_word(OP_CHARGER, 1'b1, 127, -128, 1'b1));
		send_word(make_word(OP_TICK, 1'b1, 127, -128, 1'b0));
		send_word(make_word(OP_TICK, 1'b1, 60, 50, 1'b1));
		send_word(make_word(OP_TICK, 1'b0, 54, 46, 1'b1));
		send_word(make_word(OP_TICK, 1'b1, -128, 127, 1'b1));
	endtask

	task automatic test_walk_to_idle();
		program_regs(1'b1, 40, 35, 5, 2, 127);
		run_cool_session(3);
		// disabled guard: start refused, unarmed tick still stops
		program_regs(1'b0, 40, 35, 5, 2, 127);
		send_word(make_word(OP_CHARGER, 1'b1, 30, 30, 1'b1));
		send_word(make_word(OP_TICK, 1'b0, 100, -100, 1'b1));
		send_word(make_word(OP_CHARGER, 1'b0, 30, 30, 1'b1));
		program_regs(1'b1, 40, 35, 5, 2, 127);
	endtask

	task automatic test_cool_sessions(int count);
		int fst;
		int opn;
		repeat (count) begin
			fst = rnd(20, 127);
			opn = rnd(-20, fst);
			program_regs(1'b1, rnd_level(), rnd_level(), opn, rnd(-128, opn), fst);
			run_cool_session(rnd(1, 5));
		end
	endtask

	task automatic test_reg_extremes();
		program_regs(1'b1, -128, -128, -128, -128, -128);
		send_word(make_word(OP_CHARGER, 1'b1, 0, 0, 1'b1));
		send_word(make_word(OP_TICK, 1'b1, -128, 5, 1'b0));
		send_word(make_word(OP_TICK, 1'b1, -128, 127, 1'b1));
		send_word(make_word(OP_TICK, 1'b1, 127, -128, 1'b1));
		program_regs(1'b1, 127, 127, 127, 127, 127);
		send_word(make_word(OP_TICK, 1'b1, 127, -128, 1'b1));
		send_word(make_word(OP_TICK, 1'b1, 127, 0, 1'b1));
		send_word(make_word(OP_TICK, 1'b1, 0, 100, 1'b0));
		send_word(make_word(OP_TICK, 1'b0, 126, -1, 1'b1));
		send_word(make_word(OP_CHARGER, 1'b1, 127, 127, 1'b1));
	endtask

	task automatic test_hot_mix(int count);
		int sel;
		for (int i = 0; i < count; i++) begin
			if (i == 0) begin
				program_regs(1'b1, 57, 54, 15, 8, 10);
			end else if (i % 50 == 0) begin
				program_regs(rnd(0, 4) != 0, rnd_level(), rnd_level(), rnd_level(),
					rnd_level(), rnd_level());
			end
			sel = rnd(0, 99);
			if (sel < 30) begin
				send_word(tick_word(1'($urandom), rnd(lim_delta_fast + 1, 255)));
			end else if (sel < 60) begin
				send_word(tick_word(1'($urandom), rnd(-255, lim_delta_fast)));
			end else if (sel < 75) begin
				send_word(charger_noise());
			end else begin
				send_word(item_t'($urandom));
			end
		end
	endtask

	initial begin : run_tests
		int spin;
		arst_n = 1'b0;
		item_bus.valid = 1'b0;
		item_bus.op = OP_CHARGER;
		item_bus.charging = 1'b0;
		item_bus.conn_temp = '0;
		item_bus.batt_temp = '0;
		item_bus.batt_valid = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_GUARD_ENABLE;
		cfg_bus.data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_gap_pct = 24;
		sink_stall_pct = 82;
		test_first_start();
		test_walk_to_idle();

		src_gap_pct = 82;
		sink_stall_pct = 24;
		test_cool_sessions(2);

		src_gap_pct = 0;
		sink_stall_pct = 0;
		test_reg_extremes();
		test_hot_mix(100);

		item_bus.valid <= 1'b0;
		spin = 0;
		while (expected_results.size() != 0 && spin < 20000) begin
			@(posedge clk);
			spin++;
		end
		repeat (4) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d words never arrived", expected_results.size()));
		if (mismatches == 0) begin
			$display("usb_connector_overtemp_guard verification clean");
		end else begin
			$display("usb_connector_overtemp_guard verification failed");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("usb_connector_overtemp_guard verification failed");
		$finish;
	end

endmodule
